>>> hw/rtl/mie_pkg.sv
// ----------------------------------------------------------------------------
// Modular inverse package
// Shared widths, control word layout and the sequencer microprogram.
// ----------------------------------------------------------------------------
package mie_pkg;

  // Operand width of value, modulus, inverse and divisor.
  localparam int DATA_WIDTH = 31;
  // Signed coefficient width: partial products reach twice the modulus.
  localparam int COEF_WIDTH = DATA_WIDTH + 2;
  // Shift count width: the alignment shift stays below DATA_WIDTH.
  localparam int SHIFT_WIDTH = $clog2(DATA_WIDTH);
  // Program counter width: eight microprogram steps.
  localparam int PC_WIDTH = 3;

  typedef logic [DATA_WIDTH-1:0]         data_t;
  typedef logic signed [COEF_WIDTH-1:0]  coef_t;
  typedef logic [SHIFT_WIDTH-1:0]        shift_t;
  typedef logic [PC_WIDTH-1:0]           pc_t;

  // Datapath operations selected by the control word.
  typedef enum logic [2:0] {
    OP_LOAD,
    OP_INIT,
    OP_ALIGN,
    OP_SUB,
    OP_SWAP,
    OP_FIX_SIGN,
    OP_FIX_RANGE,
    OP_EMIT
  } op_e;

  // Jump conditions; a step falls through to the next one when false.
  typedef enum logic [2:0] {
    CND_NONE,
    CND_ALWAYS,
    CND_NO_BEAT,
    CND_B_ZERO,
    CND_CAN_ALIGN,
    CND_K_NZ,
    CND_OUT_FULL
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    pc_t   target;
  } ctrl_t;

  // Status flags from the datapath back to the sequencer.
  typedef struct packed {
    logic b_zero;
    logic can_align;
    logic k_nz;
  } status_t;

  // Microprogram step addresses.
  localparam pc_t STEP_IDLE  = pc_t'(0);
  localparam pc_t STEP_TEST  = pc_t'(1);
  localparam pc_t STEP_ALIGN = pc_t'(2);
  localparam pc_t STEP_SUB   = pc_t'(3);
  localparam pc_t STEP_SWAP  = pc_t'(4);
  localparam pc_t STEP_FIX1  = pc_t'(5);
  localparam pc_t STEP_FIX2  = pc_t'(6);
  localparam pc_t STEP_EMIT  = pc_t'(7);

  // Control store. The last step falls through to the idle step by wrap.
  function automatic ctrl_t mie_rom(input pc_t pc);
    ctrl_t w;
    w = '{op: OP_LOAD, cond: CND_ALWAYS, target: STEP_IDLE};
    unique case (pc)
      STEP_IDLE:  w = '{op: OP_LOAD,      cond: CND_NO_BEAT,   target: STEP_IDLE};
      STEP_TEST:  w = '{op: OP_INIT,      cond: CND_B_ZERO,    target: STEP_FIX1};
      STEP_ALIGN: w = '{op: OP_ALIGN,     cond: CND_CAN_ALIGN, target: STEP_ALIGN};
      STEP_SUB:   w = '{op: OP_SUB,       cond: CND_K_NZ,      target: STEP_SUB};
      STEP_SWAP:  w = '{op: OP_SWAP,      cond: CND_ALWAYS,    target: STEP_TEST};
      STEP_FIX1:  w = '{op: OP_FIX_SIGN,  cond: CND_NONE,      target: STEP_IDLE};
      STEP_FIX2:  w = '{op: OP_FIX_RANGE, cond: CND_NONE,      target: STEP_IDLE};
      STEP_EMIT:  w = '{op: OP_EMIT,      cond: CND_OUT_FULL,  target: STEP_EMIT};
      default:    w = '{op: OP_LOAD,      cond: CND_ALWAYS,    target: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

>>> hw/rtl/mie_in_if.sv
// ----------------------------------------------------------------------------
// Modular inverse input channel
// Valid/ready channel carrying one value and modulus per beat.
// ----------------------------------------------------------------------------
interface mie_in_if;
  import mie_pkg::*;

  logic  valid;
  logic  ready;
  data_t value;
  data_t modulus;

  modport source (output valid, value, modulus, input ready);
  modport sink (input valid, value, modulus, output ready);

endinterface

>>> hw/rtl/mie_out_if.sv
// ----------------------------------------------------------------------------
// Modular inverse output channel
// Valid/ready channel carrying one inverse and gcd per beat.
// ----------------------------------------------------------------------------
interface mie_out_if;
  import mie_pkg::*;

  logic  valid;
  logic  ready;
  data_t inverse;
  data_t divisor;

  modport source (output valid, inverse, divisor, input ready);
  modport sink (input valid, inverse, divisor, output ready);

endinterface

>>> hw/rtl/mie_datapath.sv
// ----------------------------------------------------------------------------
// Modular inverse datapath
// Remainder pair, coefficient pair and shift-subtract divider registers,
// driven one operation per cycle by the sequencer's control word.
// ----------------------------------------------------------------------------
module mie_datapath (
  input  logic            clk_i,
  input  mie_pkg::op_e    op_i,
  input  mie_pkg::data_t  value_i,
  input  mie_pkg::data_t  modulus_i,
  output mie_pkg::status_t status_o,
  output mie_pkg::data_t  inverse_o,
  output mie_pkg::data_t  divisor_o
);
  import mie_pkg::*;

  // a: remainder being divided (old r); b: divisor (r); d: aligned divisor.
  data_t  a_q, a_d;
  data_t  b_q, b_d;
  data_t  d_q, d_d;
  data_t  m_q, m_d;
  // sa, sb: coefficients of value for a and b; t: quotient times sb so far.
  coef_t  sa_q, sa_d;
  coef_t  sb_q, sb_d;
  coef_t  t_q, t_d;
  shift_t k_q, k_d;

  logic [DATA_WIDTH:0] d_dbl;
  logic                can_align;
  logic                fits;
  coef_t               t_dbl;
  coef_t               m_ext;

  // Divider helpers: alignment test, subtract test and Horner doubling.
  assign d_dbl     = {d_q, 1'b0};
  assign can_align = d_dbl <= {1'b0, a_q};
  assign fits      = d_q <= a_q;
  assign t_dbl     = t_q <<< 1;
  assign m_ext     = $signed({{(COEF_WIDTH-DATA_WIDTH){1'b0}}, m_q});

  // Next-state logic for each datapath operation.
  always_comb begin
    a_d  = a_q;
    b_d  = b_q;
    d_d  = d_q;
    m_d  = m_q;
    sa_d = sa_q;
    sb_d = sb_q;
    t_d  = t_q;
    k_d  = k_q;
    unique case (op_i)
      OP_LOAD: begin
        a_d  = modulus_i;
        b_d  = value_i;
        m_d  = modulus_i;
        sa_d = '0;
        sb_d = coef_t'(1);
      end
      OP_INIT: begin
        d_d = b_q;
        k_d = '0;
        t_d = '0;
      end
      OP_ALIGN: begin
        if (can_align) begin
          d_d = d_dbl[DATA_WIDTH-1:0];
          k_d = k_q + shift_t'(1);
        end
      end
      OP_SUB: begin
        if (fits) begin
          a_d = a_q - d_q;
          t_d = t_dbl + sb_q;
        end else begin
          t_d = t_dbl;
        end
        if (k_q != '0) begin
          d_d = d_q >> 1;
          k_d = k_q - shift_t'(1);
        end
      end
      OP_SWAP: begin
        a_d  = b_q;
        b_d  = a_q;
        sa_d = sb_q;
        sb_d = sa_q - t_q;
      end
      OP_FIX_SIGN: begin
        if (sa_q[COEF_WIDTH-1]) begin
          sa_d = sa_q + m_ext;
        end
      end
      OP_FIX_RANGE: begin
        if (m_q == '0) begin
          sa_d = '0;
        end else if (sa_q >= m_ext) begin
          sa_d = sa_q - m_ext;
        end
      end
      OP_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  // Working registers carry no reset; every item starts with a load.
  always_ff @(posedge clk_i) begin
    a_q  <= a_d;
    b_q  <= b_d;
    d_q  <= d_d;
    m_q  <= m_d;
    sa_q <= sa_d;
    sb_q <= sb_d;
    t_q  <= t_d;
    k_q  <= k_d;
  end

  // Status back to the sequencer and results to the output register.
  assign status_o.b_zero    = (b_q == '0);
  assign status_o.can_align = can_align;
  assign status_o.k_nz      = (k_q != '0);
  assign inverse_o          = sa_q[DATA_WIDTH-1:0];
  assign divisor_o          = a_q;

endmodule

>>> hw/rtl/modular_inverse_ext_euclid.sv
// Run time is data dependent: each Euclid step runs the zero test, the alignment
// shifts, the subtract steps and the swap, around load, sign fix, range fix and emit.
// One item at a time: a new beat is taken only in the idle step, after the
// previous result has been emitted into the output register.
// Reset (asynchronous, active low) returns the sequencer to idle and empties
// the output register; the datapath registers are not reset.
// ----------------------------------------------------------------------------
// Modular inverse by extended Euclid
// Microcoded sequencer over a shift-subtract Euclid datapath, with a
// registered output beat holding the reduced coefficient and the gcd.
// ----------------------------------------------------------------------------
module modular_inverse_ext_euclid (
  input  logic             clk_i,
  input  logic             rst_ni,
  mie_in_if.sink           in_i,
  mie_out_if.source        out_o
);
  import mie_pkg::*;

  pc_t     pc_q, pc_d;
  ctrl_t   ctrl;
  status_t status;
  logic    in_fire;
  logic    out_full;
  logic    jump;
  logic    emit;
  logic    out_valid_q, out_valid_d;
  data_t   inverse_q;
  data_t   divisor_q;
  data_t   dp_inverse;
  data_t   dp_divisor;

  // Fetch the control word for the current step.
  assign ctrl     = mie_rom(pc_q);
  assign in_fire  = in_i.valid && in_i.ready;
  assign out_full = out_valid_q && !out_o.ready;
  assign emit     = (ctrl.op == OP_EMIT) && !out_full;

  // Jump condition select.
  always_comb begin
    unique case (ctrl.cond)
      CND_NONE:      jump = 1'b0;
      CND_ALWAYS:    jump = 1'b1;
      CND_NO_BEAT:   jump = !in_fire;
      CND_B_ZERO:    jump = status.b_zero;
      CND_CAN_ALIGN: jump = status.can_align;
      CND_K_NZ:      jump = status.k_nz;
      CND_OUT_FULL:  jump = out_full;
      default:       jump = 1'b1;
    endcase
  end

  // Next step and output beat state.
  always_comb begin
    pc_d        = jump ? ctrl.target : pc_q + pc_t'(1);
    out_valid_d = out_valid_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= STEP_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      inverse_q <= dp_inverse;
      divisor_q <= dp_divisor;
    end
  end

  mie_datapath u_datapath (
    .clk_i     (clk_i),
    .op_i      (ctrl.op),
    .value_i   (in_i.value),
    .modulus_i (in_i.modulus),
    .status_o  (status),
    .inverse_o (dp_inverse),
    .divisor_o (dp_divisor)
  );

  assign in_i.ready    = (pc_q == STEP_IDLE);
  assign out_o.valid   = out_valid_q;
  assign out_o.inverse = inverse_q;
  assign out_o.divisor = divisor_q;

`ifndef SYNTHESIS
  // An accepted beat always starts the Euclid loop on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> pc_q == STEP_TEST)
    else $error("sequencer did not start after input beat");

  // The sequencer leaves idle only through an input beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == STEP_IDLE) && !in_fire |=> pc_q == STEP_IDLE)
    else $error("sequencer left idle without an input beat");

  // Reaching the emit step with room in the output register yields a beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == STEP_EMIT) && !out_full |=> out_valid_q && (pc_q == STEP_IDLE))
    else $error("result not presented after emit step");

  // A remainder swap never happens with a zero divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == STEP_SWAP) |-> !status.b_zero)
    else $error("Euclid step ran with zero divisor");
`endif

endmodule
